### src/ctlp_pkg.sv
// ----------------------------------------------------------------------------
// ctlp_pkg
// Shared constants and types of the CNF text literal parser.
// ----------------------------------------------------------------------------
package ctlp_pkg;

  localparam int VAR_BITS   = 20;
  localparam int COUNT_BITS = 24;

  localparam int VALUE_W = 24;
  localparam int LIT_W   = (VAR_BITS > 23) ? 23 : VAR_BITS;
  localparam int CNT_W   = (COUNT_BITS > 24) ? 24 : COUNT_BITS;
  localparam int ACC_W   = (CNT_W > LIT_W) ? CNT_W : LIT_W;
  localparam int PROD_W  = ACC_W + 4;

  localparam logic [PROD_W-1:0] LIT_LIMIT = PROD_W'((64'd1 << LIT_W) - 64'd1);
  localparam logic [PROD_W-1:0] CNT_LIMIT = PROD_W'((64'd1 << CNT_W) - 64'd1);

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [2:0] KIND_LITERAL    = 3'd0;
  localparam logic [2:0] KIND_CLAUSE_END = 3'd1;
  localparam logic [2:0] KIND_VAR_COUNT  = 3'd2;
  localparam logic [2:0] KIND_CLS_COUNT  = 3'd3;
  localparam logic [2:0] KIND_ERROR      = 3'd4;

  localparam logic CAUSE_ILLEGAL = 1'b0;
  localparam logic CAUSE_RANGE   = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;
    logic               cause;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_out_t;

endpackage

### src/cnf_text_literal_parser.sv
// ----------------------------------------------------------------------------
// cnf_text_literal_parser
// Parses DIMACS CNF text one byte per word and streams out literal codes,
// clause ends, header counts and errors.
// An accepted byte is registered in the input stage, and its result in the output stage.
// Throughput is one byte per cycle while the output word is not stalled, set by the single-pass parser step.
// A stalled output word stops the parser, also for bytes without a result.
// Reset is asynchronous and active low and returns the parser to the preamble.
// ----------------------------------------------------------------------------
module cnf_text_literal_parser
  import ctlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // in_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [VALUE_W-1:0] m_axis_tdata_o,  // value
  output logic [3:0]         m_axis_tuser_o,  // kind[2:0], error_cause
  output logic               m_axis_tlast_o   // last_clause
);

  in_item_t    item;
  result_out_t result;
  logic        out_free;
  logic        step;

  assign step = item.valid && out_free;

  ctlp_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .take_i          (step),
    .item_o          (item)
  );

  ctlp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (item.data),
    .result_o (result)
  );

  ctlp_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .result_i        (result),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### src/ctlp_in_stage.sv
// ----------------------------------------------------------------------------
// ctlp_in_stage
// Input register that holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module ctlp_in_stage
  import ctlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       take_i,
  output in_item_t   item_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign s_axis_tready_o = !valid_q || take_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_axis_tdata_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

### src/ctlp_parser.sv
// ----------------------------------------------------------------------------
// ctlp_parser
// Parser state and the single-pass next-state and result logic for one word.
// ----------------------------------------------------------------------------
module ctlp_parser
  import ctlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output result_out_t result_o
);

  localparam logic [3:0] PH_PRE_LS    = 4'd0;
  localparam logic [3:0] PH_PRE_SKIP  = 4'd1;
  localparam logic [3:0] PH_HDR_KEY   = 4'd2;
  localparam logic [3:0] PH_HDR_NUM   = 4'd3;
  localparam logic [3:0] PH_HDR_SKIP  = 4'd4;
  localparam logic [3:0] PH_BODY      = 4'd5;
  localparam logic [3:0] PH_BODY_SKIP = 4'd6;
  localparam logic [3:0] PH_DONE      = 4'd7;
  localparam logic [3:0] PH_HALT      = 4'd8;

  logic [3:0]         phase_q, phase_d;
  logic [1:0]         kw_q, kw_d;
  logic [ACC_W-1:0]   accum_q, accum_d;
  logic               neg_q, neg_d;
  logic               active_q, active_d;
  logic               idx_q, idx_d;
  logic [CNT_W-1:0]   expected_q, expected_d;
  logic [CNT_W-1:0]   done_q, done_d;
  logic [VALUE_W-1:0] line_q, line_d;

  logic               is_dig, is_nl, is_ws, is_pct, is_minus;
  logic [3:0]         digit;
  logic [PROD_W-1:0]  prod, limit;
  logic [CNT_W:0]     done_inc;
  logic [ACC_W-1:0]   lit_m1;
  logic               body, hdr, act, line_inc, emit, tok_ok;
  result_t            res;

  assign is_dig   = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_nl    = byte_i == CH_NL;
  assign is_ws    = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign is_pct   = byte_i == CH_PCT;
  assign is_minus = byte_i == CH_MINUS;
  assign digit    = 4'(byte_i - CH_ZERO);
  assign prod     = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + PROD_W'(digit);
  assign done_inc = {1'b0, done_q} + (CNT_W + 1)'(1);
  assign lit_m1   = accum_q - ACC_W'(1);

  always_comb begin
    phase_d    = phase_q;
    kw_d       = kw_q;
    accum_d    = accum_q;
    neg_d      = neg_q;
    active_d   = active_q;
    idx_d      = idx_q;
    expected_d = expected_q;
    done_d     = done_q;
    line_inc   = 1'b0;
    emit       = 1'b0;
    res        = '0;
    body       = 1'b0;
    hdr        = 1'b0;
    act        = active_q;
    tok_ok     = 1'b1;
    limit      = LIT_LIMIT;

    case (phase_q)
      PH_PRE_LS: begin
        if (byte_i == CH_C) begin
          phase_d = PH_PRE_SKIP;
        end else if (byte_i == CH_P) begin
          phase_d = PH_HDR_KEY;
          kw_d    = 2'd0;
        end else if (done_q >= expected_q) begin
          phase_d = PH_DONE;
        end else begin
          phase_d  = PH_BODY;
          active_d = 1'b0;
          act      = 1'b0;
          body     = 1'b1;
        end
      end
      PH_PRE_SKIP: begin
        if (is_nl) begin
          line_inc = 1'b1;
          phase_d  = PH_PRE_LS;
        end
      end
      PH_HDR_KEY: begin
        line_inc = is_nl;
        if (kw_q == 2'd0 && byte_i == CH_C) begin
          kw_d = 2'd1;
        end else if (kw_q == 2'd1 && byte_i == CH_N) begin
          kw_d = 2'd2;
        end else if (kw_q == 2'd2 && byte_i == CH_F) begin
          kw_d     = 2'd0;
          phase_d  = PH_HDR_NUM;
          idx_d    = 1'b0;
          active_d = 1'b0;
        end
      end
      PH_HDR_NUM: begin
        hdr = 1'b1;
      end
      PH_HDR_SKIP: begin
        if (is_nl) begin
          line_inc = 1'b1;
          phase_d  = PH_HDR_NUM;
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      PH_BODY_SKIP: begin
        if (is_nl) begin
          line_inc = 1'b1;
          phase_d  = PH_BODY;
        end
      end
      default: begin
      end
    endcase

    if (hdr) begin
      limit = CNT_LIMIT;
    end

    if (body || hdr) begin
      if (act && is_dig) begin
        if (prod > limit) begin
          phase_d  = PH_HALT;
          active_d = 1'b0;
          emit     = 1'b1;
          res      = '{KIND_ERROR, line_q, CAUSE_RANGE, 1'b0};
        end else begin
          accum_d = ACC_W'(prod);
        end
      end else begin
        active_d = 1'b0;
        if (act && body && accum_q == '0 && done_inc >= {1'b0, expected_q}) begin
          done_d  = CNT_W'(done_inc);
          phase_d = PH_DONE;
          emit    = 1'b1;
          res     = '{KIND_CLAUSE_END, '0, 1'b0, 1'b1};
        end else if (act && hdr && idx_q) begin
          idx_d      = 1'b0;
          expected_d = CNT_W'(accum_q);
          done_d     = '0;
          phase_d    = is_nl ? PH_PRE_LS : PH_PRE_SKIP;
          line_inc   = is_nl;
          emit       = 1'b1;
          res        = '{KIND_CLS_COUNT, VALUE_W'(accum_q), 1'b0, 1'b0};
        end else begin
          if (act) begin
            emit = 1'b1;
            if (hdr) begin
              idx_d = 1'b1;
              res   = '{KIND_VAR_COUNT, VALUE_W'(accum_q), 1'b0, 1'b0};
            end else if (accum_q == '0) begin
              done_d = CNT_W'(done_inc);
              res    = '{KIND_CLAUSE_END, '0, 1'b0, 1'b0};
            end else begin
              res = '{KIND_LITERAL, {(VALUE_W - 1)'(lit_m1), neg_q}, 1'b0, 1'b0};
            end
          end
          tok_ok = is_ws || is_nl || is_pct || is_dig || (body && is_minus);
          if (!tok_ok) begin
            phase_d  = PH_HALT;
            active_d = 1'b0;
            emit     = 1'b1;
            res      = '{KIND_ERROR, line_q, CAUSE_ILLEGAL, 1'b0};
          end else begin
            line_inc = is_nl;
            if (is_pct) begin
              phase_d = body ? PH_BODY_SKIP : PH_HDR_SKIP;
            end
            if (is_dig || is_minus) begin
              active_d = 1'b1;
              neg_d    = is_minus;
              accum_d  = is_minus ? '0 : ACC_W'(digit);
            end
          end
        end
      end
    end

    line_d = (line_inc && line_q != '1) ? line_q + VALUE_W'(1) : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PRE_LS;
      kw_q       <= 2'd0;
      accum_q    <= '0;
      neg_q      <= 1'b0;
      active_q   <= 1'b0;
      idx_q      <= 1'b0;
      expected_q <= '0;
      done_q     <= '0;
      line_q     <= VALUE_W'(1);
    end else if (step_i) begin
      phase_q    <= phase_d;
      kw_q       <= kw_d;
      accum_q    <= accum_d;
      neg_q      <= neg_d;
      active_q   <= active_d;
      idx_q      <= idx_d;
      expected_q <= expected_d;
      done_q     <= done_d;
      line_q     <= line_d;
    end
  end

  assign result_o.valid = emit;
  assign result_o.res   = res;

endmodule

### src/ctlp_out_stage.sv
// ----------------------------------------------------------------------------
// ctlp_out_stage
// Result register that drives the output stream and holds a stalled word.
// ----------------------------------------------------------------------------
module ctlp_out_stage
  import ctlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  result_out_t        result_i,
  output logic               free_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [VALUE_W-1:0] m_axis_tdata_o,  // value
  output logic [3:0]         m_axis_tuser_o,  // kind[2:0], error_cause
  output logic               m_axis_tlast_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign free_o = !valid_q || m_axis_tready_i;
  assign load   = step_i && result_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result_i.res;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.value;
  assign m_axis_tuser_o  = {res_q.cause, res_q.kind};
  assign m_axis_tlast_o  = res_q.last;

endmodule

### src/ctlp_checker.sv
// ----------------------------------------------------------------------------
// ctlp_checker
// Port-level assertions on the CNF text literal parser, bound to the top.
// ----------------------------------------------------------------------------
module ctlp_checker
  import ctlp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [7:0]         s_axis_tdata_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [VALUE_W-1:0] m_axis_tdata_o,
  input logic [3:0]         m_axis_tuser_o,
  input logic               m_axis_tlast_o
);

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !$isunknown(s_axis_tdata_i))
    else $error("Accepted input word is unknown.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("Stalled output word changed.");

  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input stalled while the output register is empty.");

  a_last_on_clause_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tuser_o[2:0] == KIND_CLAUSE_END && m_axis_tdata_o == '0)
    else $error("Last flag on a word that is not a clause end.");

  a_cause_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tuser_o[2:0] == KIND_ERROR)
    else $error("Error cause set on a word that is not an error.");

endmodule

bind cnf_text_literal_parser ctlp_checker u_ctlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
